// File: design/multi_family_prng_defines.svh
// Assertion macros shared by the generator RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef MULTI_FAMILY_PRNG_DEFINES_SVH
`define MULTI_FAMILY_PRNG_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfp assertion failed");

// Next-cycle implication, checked outside reset
`define MFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfp assertion failed");

`endif

// File: design/mfp_pkg.sv
// Package for the multi-family generator: family codes, commands, constants
// and the request/response structs of the shared multiplier. No dependencies.
`default_nettype none

package mfp_pkg;

  // Family codes
  localparam logic [3:0] FAM_LCG48      = 4'd0;
  localparam logic [3:0] FAM_LCG15      = 4'd1;
  localparam logic [3:0] FAM_LCG31      = 4'd2;
  localparam logic [3:0] FAM_XS32       = 4'd3;
  localparam logic [3:0] FAM_XS64S      = 4'd4;
  localparam logic [3:0] FAM_SPLITMIX   = 4'd5;
  localparam logic [3:0] FAM_PCG32      = 4'd6;
  localparam logic [3:0] FAM_LCG64      = 4'd7;
  localparam logic [3:0] FAM_XOSHIRO256 = 4'd8;
  localparam logic [3:0] FAM_XOSHIRO128 = 4'd9;
  localparam logic [3:0] FAM_XOROSHIRO  = 4'd10;
  localparam logic [3:0] FAM_PCG64      = 4'd11;

  // Commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Arithmetic constants
  localparam logic [63:0] LCG48_MUL   = 64'h0000_0005_DEEC_E66D;
  localparam logic [63:0] LCG48_ADD   = 64'd11;
  localparam logic [63:0] LCG15_MUL   = 64'd214013;
  localparam logic [31:0] LCG15_ADD   = 32'd2531011;
  localparam logic [63:0] LCG31_MUL   = 64'd1103515245;
  localparam logic [31:0] LCG31_ADD   = 32'd12345;
  localparam logic [63:0] XS64S_MUL   = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] SM_GAMMA    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2     = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] LCG64_MUL   = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LCG64_ADD   = 64'h1405_7B7E_F767_814F;
  localparam logic [63:0] P64_ML      = 64'h4385_DF64_9FCC_F645;
  localparam logic [63:0] P64_MH      = 64'h2360_ED05_1FC6_5DA4;
  localparam logic [63:0] P64_INC_HI  = 64'h5851_F42D_4C95_7F2D;

  // Multiplier request and response
  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] y;
  } mfp_mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mfp_mul_rsp_t;

endpackage

`default_nettype wire

// File: design/mfp_mul.sv
// Shared 64x64 -> 128 multiplier built from one 32x32 multiplier, one
// partial product per cycle. Depends on mfp_pkg.
`default_nettype none

module mfp_mul
  import mfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mfp_mul_req_t req,
  output mfp_mul_rsp_t      rsp
);

  logic [63:0]  x_r, x_nxt, y_r, y_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   sh_r, sh_nxt;
  logic         pp_vld_r, pp_vld_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  opx, opy;

  // Pick halves for the current partial product
  assign opx = cnt_r[0] ? x_r[63:32] : x_r[31:0];
  assign opy = cnt_r[1] ? y_r[63:32] : y_r[31:0];

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    pp_nxt     = pp_r;
    sh_nxt     = sh_r;
    pp_vld_nxt = 1'b0;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;

    // Accumulate the registered partial product at its weight
    if (pp_vld_r) begin
      unique case (sh_r)
        2'd0:    acc_nxt = acc_r + {64'd0, pp_r};
        2'd1:    acc_nxt = acc_r + {32'd0, pp_r, 32'd0};
        default: acc_nxt = acc_r + {pp_r, 64'd0};
      endcase
    end

    if (req.start) begin
      x_nxt    = req.x;
      y_nxt    = req.y;
      acc_nxt  = '0;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r[2]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        pp_nxt     = {32'd0, opx} * {32'd0, opy};
        sh_nxt     = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
        pp_vld_nxt = 1'b1;
        cnt_nxt    = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    pp_r   <= pp_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      done_r   <= done_nxt;
      pp_vld_r <= pp_vld_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

// File: design/multi_family_prng.sv
// Top level of the multi-family generator: sequencer, state words, output
// register. Depends on mfp_pkg, mfp_mul and multi_family_prng_defines.svh.
//
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  input   | in_valid in_stall in_cmd in_seed | in
//  result  | out_valid out_stall out_value    | out
//  config  | cfg_wr_en cfg_wr_data            | in
//
// A multiply round issues in S_EXEC, waits in S_WAIT on the shared 32x32
// multiplier and applies the product in S_POST. Draws without a multiply
// finish in S_EXEC; LCG, xorshift64* and pcg32 draws take one round, splitmix
// two, pcg64 three. Loads of families 0 to 7 need no multiply; seed-expanding
// loads take two rounds per mixed word. The input is stalled until the item is
// done, so a new item is taken only after it. Reset clears the state words and
// family. A draw does not finish while a previous result is held by out_stall.
`default_nettype none

module multi_family_prng
  import mfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [63:0] in_seed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data
);

`include "multi_family_prng_defines.svh"

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_POST} state_t;

  state_t       state_r, state_nxt;
  logic         cmd_r, cmd_nxt;
  logic [2:0]   phase_r, phase_nxt;
  logic [3:0]   fam_r;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [63:0]  ctr_r, ctr_nxt, z_r, z_nxt, w_r, w_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_value_r, out_value_nxt;

  mfp_mul_req_t mul_req;
  mfp_mul_rsp_t mul_rsp;

  logic [3:0]   fam;
  logic         out_free, go, do_mix, mix_last;
  logic [63:0]  mix_src, mix_c, p_lo, p_hi, mix_out;
  logic [63:0]  x1, x2, x3, t64, c1, d1, b1, a1, b5, rl, r64;
  logic [31:0]  y1, y2, s0, s1, s2, s3, s15, srl, r32, t32;
  logic [31:0]  xs32;
  logic [63:0]  xs64, lo, hi;
  logic [127:0] dbl64;
  logic [63:0]  dbl32;

  mfp_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  assign fam      = (fam_r > FAM_PCG64) ? FAM_PCG64 : fam_r;
  assign out_free = !out_valid_r || !out_stall;
  assign go       = (cmd_r == CMD_LOAD) || out_free;
  assign in_stall = (state_r != S_IDLE);
  assign mix_last = (fam == FAM_XOSHIRO256) ? (phase_r == 3'd7) : (phase_r == 3'd3);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    ctr_nxt       = ctr_r;
    z_nxt         = z_r;
    w_nxt         = w_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_req       = '0;
    do_mix        = 1'b0;
    x1 = '0; x2 = '0; x3 = '0; t64 = '0; c1 = '0; d1 = '0; b1 = '0; a1 = '0;
    b5 = '0; rl = '0; r64 = '0; y1 = '0; y2 = '0; s0 = '0; s1 = '0; s2 = '0;
    s3 = '0; s15 = '0; srl = '0; r32 = '0; t32 = '0; xs32 = '0; xs64 = '0;
    lo = '0; hi = '0; dbl64 = '0; dbl32 = '0;

    mix_src = (cmd_r == CMD_DRAW) ? a_r : ctr_r;
    mix_c   = mix_src + SM_GAMMA;
    p_lo    = mul_rsp.prod[63:0];
    p_hi    = mul_rsp.prod[127:64];
    mix_out = p_lo ^ (p_lo >> 31);

    unique case (state_r)
      // Take an item; a load clears the state words
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          ctr_nxt   = in_seed;
          phase_nxt = 3'd0;
          if (in_cmd == CMD_LOAD) begin
            a_nxt = '0;
            b_nxt = '0;
            c_nxt = '0;
            d_nxt = '0;
          end
          state_nxt = S_EXEC;
        end
      end

      // Issue a multiply or finish a step that needs none
      S_EXEC: begin
        if (go) begin
          if (cmd_r == CMD_LOAD) begin
            state_nxt = S_IDLE;
            unique case (fam)
              FAM_LCG48:    a_nxt = {16'd0, ctr_r[47:0] ^ LCG48_MUL[47:0]};
              FAM_LCG15:    a_nxt = {32'd0, ctr_r[31:0]};
              FAM_LCG31:    a_nxt = {33'd0, ctr_r[30:0]};
              FAM_XS32:     a_nxt = (ctr_r[31:0] != 32'd0) ? {32'd0, ctr_r[31:0]} : 64'd1;
              FAM_XS64S:    a_nxt = (ctr_r != 64'd0) ? ctr_r : 64'd1;
              FAM_SPLITMIX: a_nxt = ctr_r;
              FAM_PCG32: begin
                a_nxt = ctr_r;
                b_nxt = LCG64_ADD;
              end
              FAM_LCG64:    a_nxt = ctr_r;
              default:      do_mix = 1'b1;
            endcase
          end else begin
            state_nxt = S_WAIT;
            unique case (fam)
              FAM_LCG48: begin
                mul_req = '{start: 1'b1, x: a_r, y: LCG48_MUL};
              end
              FAM_LCG15: begin
                mul_req = '{start: 1'b1, x: a_r, y: LCG15_MUL};
              end
              FAM_LCG31: begin
                mul_req = '{start: 1'b1, x: a_r, y: LCG31_MUL};
              end
              FAM_XS32: begin
                y1 = a_r[31:0] ^ (a_r[31:0] << 13);
                y2 = y1 ^ (y1 >> 17);
                s0 = y2 ^ (y2 << 5);
                a_nxt         = {32'd0, s0};
                out_value_nxt = s0;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
              FAM_XS64S: begin
                x1 = a_r ^ (a_r >> 12);
                x2 = x1 ^ (x1 << 25);
                x3 = x2 ^ (x2 >> 27);
                a_nxt   = x3;
                mul_req = '{start: 1'b1, x: x3, y: XS64S_MUL};
              end
              FAM_SPLITMIX: do_mix = 1'b1;
              FAM_PCG32: begin
                w_nxt   = a_r;
                mul_req = '{start: 1'b1, x: a_r, y: LCG64_MUL};
              end
              FAM_LCG64: begin
                mul_req = '{start: 1'b1, x: a_r, y: LCG64_MUL};
              end
              FAM_XOSHIRO256: begin
                b5  = b_r + (b_r << 2);
                rl  = {b5[56:0], b5[63:57]};
                r64 = rl + (rl << 3);
                t64 = b_r << 17;
                c1  = c_r ^ a_r;
                d1  = d_r ^ b_r;
                b1  = b_r ^ c1;
                a1  = a_r ^ d1;
                a_nxt = a1;
                b_nxt = b1;
                c_nxt = c1 ^ t64;
                d_nxt = {d1[18:0], d1[63:19]};
                out_value_nxt = r64[63:32];
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
              FAM_XOSHIRO128: begin
                s0  = a_r[31:0];
                s1  = b_r[31:0];
                s2  = c_r[31:0];
                s3  = d_r[31:0];
                s15 = s1 + (s1 << 2);
                srl = {s15[24:0], s15[31:25]};
                r32 = srl + (srl << 3);
                t32 = s1 << 9;
                s2  = s2 ^ s0;
                s3  = s3 ^ s1;
                s1  = s1 ^ s2;
                s0  = s0 ^ s3;
                s2  = s2 ^ t32;
                a_nxt = {32'd0, s0};
                b_nxt = {32'd0, s1};
                c_nxt = {32'd0, s2};
                d_nxt = {32'd0, s3[20:0], s3[31:21]};
                out_value_nxt = r32;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
              FAM_XOROSHIRO: begin
                r64 = a_r + b_r;
                x1  = b_r ^ a_r;
                a_nxt = {a_r[39:0], a_r[63:40]} ^ x1 ^ (x1 << 16);
                b_nxt = {x1[26:0], x1[63:27]};
                out_value_nxt = r64[63:32];
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end
              default: begin
                unique case (phase_r)
                  3'd0:    mul_req = '{start: 1'b1, x: a_r, y: P64_ML};
                  3'd1:    mul_req = '{start: 1'b1, x: a_r, y: P64_MH};
                  default: mul_req = '{start: 1'b1, x: b_r, y: P64_ML};
                endcase
              end
            endcase
          end

          // Splitmix round: advance counter, then two multiplies
          if (do_mix) begin
            state_nxt = S_WAIT;
            if (!phase_r[0]) begin
              if (cmd_r == CMD_DRAW) begin
                a_nxt = mix_c;
              end else begin
                ctr_nxt = mix_c;
              end
              mul_req = '{start: 1'b1, x: mix_c ^ (mix_c >> 30), y: SM_MUL1};
            end else begin
              mul_req = '{start: 1'b1, x: z_r ^ (z_r >> 27), y: SM_MUL2};
            end
          end
        end
      end

      // Hold until the product is ready
      S_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = S_POST;
        end
      end

      // Apply the product
      S_POST: begin
        if (go) begin
          state_nxt = S_IDLE;
          if ((cmd_r == CMD_LOAD) || (fam == FAM_SPLITMIX)) begin
            if (!phase_r[0]) begin
              z_nxt     = p_lo;
              phase_nxt = phase_r + 3'd1;
              state_nxt = S_EXEC;
            end else if (cmd_r == CMD_DRAW) begin
              out_value_nxt = mix_out[63:32];
              out_valid_nxt = 1'b1;
            end else begin
              if (fam == FAM_XOSHIRO256) begin
                unique case (phase_r[2:1])
                  2'd0:    a_nxt = mix_out;
                  2'd1:    b_nxt = mix_out;
                  2'd2:    c_nxt = mix_out;
                  default: d_nxt = mix_out;
                endcase
              end else if (fam == FAM_XOSHIRO128) begin
                if (!phase_r[1]) begin
                  a_nxt = {32'd0, mix_out[31:0]};
                  b_nxt = {32'd0, mix_out[63:32]};
                end else begin
                  c_nxt = {32'd0, mix_out[31:0]};
                  d_nxt = {32'd0, mix_out[63:32]};
                end
              end else if (!phase_r[1]) begin
                a_nxt = mix_out;
              end else begin
                b_nxt = mix_out;
              end
              if (!mix_last) begin
                phase_nxt = phase_r + 3'd1;
                state_nxt = S_EXEC;
              end
            end
          end else begin
            out_valid_nxt = 1'b1;
            unique case (fam)
              FAM_LCG48: begin
                x1 = p_lo + LCG48_ADD;
                a_nxt         = {16'd0, x1[47:0]};
                out_value_nxt = x1[47:16];
              end
              FAM_LCG15: begin
                y1 = p_lo[31:0] + LCG15_ADD;
                a_nxt         = {32'd0, y1};
                out_value_nxt = {17'd0, y1[30:16]};
              end
              FAM_LCG31: begin
                y1 = p_lo[31:0] + LCG31_ADD;
                a_nxt         = {33'd0, y1[30:0]};
                out_value_nxt = {1'b0, y1[30:0]};
              end
              FAM_XS64S: out_value_nxt = p_lo[63:32];
              FAM_PCG32: begin
                a_nxt = p_lo + (b_r | 64'd1);
                x2    = ((w_r >> 18) ^ w_r) >> 27;
                xs32  = x2[31:0];
                dbl32 = {xs32, xs32} >> w_r[63:59];
                out_value_nxt = dbl32[31:0];
              end
              FAM_LCG64: begin
                x1 = p_lo + LCG64_ADD;
                a_nxt         = x1;
                out_value_nxt = x1[63:32];
              end
              default: begin
                unique case (phase_r)
                  3'd0: begin
                    w_nxt         = p_lo;
                    z_nxt         = p_hi;
                    phase_nxt     = 3'd1;
                    state_nxt     = S_EXEC;
                    out_valid_nxt = out_valid_r && out_stall;
                  end
                  3'd1: begin
                    z_nxt         = z_r + p_lo;
                    phase_nxt     = 3'd2;
                    state_nxt     = S_EXEC;
                    out_valid_nxt = out_valid_r && out_stall;
                  end
                  default: begin
                    lo    = w_r + 64'd1;
                    hi    = z_r + p_lo + P64_INC_HI + {63'd0, (lo == 64'd0)};
                    a_nxt = lo;
                    b_nxt = hi;
                    xs64  = hi ^ lo;
                    dbl64 = {xs64, xs64} >> hi[63:58];
                    out_value_nxt = dbl64[63:32];
                  end
                endcase
              end
            endcase
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, words and registered outputs
  always_ff @(posedge clk) begin
    ctr_r       <= ctr_nxt;
    z_r         <= z_nxt;
    w_r         <= w_nxt;
    out_value_r <= out_value_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_LOAD;
      phase_r     <= 3'd0;
      fam_r       <= FAM_LCG48;
      a_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      d_r         <= d_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        fam_r <= cfg_wr_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `MFP_ASSERT_NXT(a_accept_to_exec, in_valid && !in_stall, state_r == S_EXEC)
  `MFP_ASSERT_IMP(a_start_from_exec, mul_req.start, state_r == S_EXEC)
  `MFP_ASSERT_IMP(a_done_in_wait, mul_rsp.done, state_r == S_WAIT)

endmodule

`default_nettype wire

// File: verif/multi_family_prng_tb.sv
// Self-checking testbench for multi_family_prng: drives seed loads and draws
// over all family codes and checks every drawn word against a local predictor.
// Depends on mfp_pkg and the multi_family_prng RTL.
`timescale 1ns / 100ps
`default_nettype none

module multi_family_prng_tb;
  import mfp_pkg::*;

  // Predicts drawn words from the generator state and checks results in order
  class prng_scoreboard;
    logic [3:0]  family;
    logic [63:0] wa, wb, wc, wd;
    logic [31:0] pending_words[$];
    int          errors;
    int          draws_checked;

    function new();
      family = FAM_LCG48;
      wa = '0; wb = '0; wc = '0; wd = '0;
      errors = 0;
      draws_checked = 0;
    endfunction

    function logic [63:0] mix_next(inout logic [63:0] ctr);
      logic [63:0] z;
      ctr = ctr + SM_GAMMA;
      z = ctr;
      z = (z ^ (z >> 30)) * SM_MUL1;
      z = (z ^ (z >> 27)) * SM_MUL2;
      return z ^ (z >> 31);
    endfunction

    function logic [63:0] rotl64(logic [63:0] v, int k);
      return (v << k) | (v >> (64 - k));
    endfunction

    function logic [31:0] rotl32(logic [31:0] v, int k);
      return (v << k) | (v >> (32 - k));
    endfunction

    function logic [3:0] active_family();
      return (family > FAM_PCG64) ? FAM_PCG64 : family;
    endfunction

    // Seed the state words by the selected family's rule
    function void load_seed(logic [63:0] seed);
      logic [63:0] ctr, u, v;
      ctr = seed;
      wa = '0; wb = '0; wc = '0; wd = '0;
      case (active_family())
        FAM_LCG48: wa = (seed ^ LCG48_MUL) & 64'hFFFF_FFFF_FFFF;
        FAM_LCG15: wa = {32'd0, seed[31:0]};
        FAM_LCG31: wa = {33'd0, seed[30:0]};
        FAM_XS32: wa = (seed[31:0] != 0) ? {32'd0, seed[31:0]} : 64'd1;
        FAM_XS64S: wa = (seed != 0) ? seed : 64'd1;
        FAM_SPLITMIX, FAM_LCG64: wa = seed;
        FAM_PCG32: begin
          wa = seed;
          wb = LCG64_ADD;
        end
        FAM_XOSHIRO256: begin
          wa = mix_next(ctr);
          wb = mix_next(ctr);
          wc = mix_next(ctr);
          wd = mix_next(ctr);
        end
        FAM_XOSHIRO128: begin
          u = mix_next(ctr);
          v = mix_next(ctr);
          wa = {32'd0, u[31:0]};
          wb = {32'd0, u[63:32]};
          wc = {32'd0, v[31:0]};
          wd = {32'd0, v[63:32]};
        end
        default: begin
          wa = mix_next(ctr);
          wb = mix_next(ctr);
        end
      endcase
    endfunction

    // Advance the state and return the drawn word
    function logic [31:0] draw_word();
      logic [63:0]  x, r, t, xs, nlo, nhi;
      logic [127:0] prod;
      logic [31:0]  s0, s1, s2, s3, r32, t32, xs32;
      logic [5:0]   rot;
      case (active_family())
        FAM_LCG48: begin
          wa = (wa * LCG48_MUL + LCG48_ADD) & 64'hFFFF_FFFF_FFFF;
          return wa[47:16];
        end
        FAM_LCG15: begin
          wa = {32'd0, wa[31:0] * LCG15_MUL[31:0] + LCG15_ADD};
          return {17'd0, wa[30:16]};
        end
        FAM_LCG31: begin
          wa = {33'd0, wa[30:0] * LCG31_MUL[30:0] + LCG31_ADD[30:0]};
          return wa[31:0];
        end
        FAM_XS32: begin
          s0 = wa[31:0];
          s0 = s0 ^ (s0 << 13);
          s0 = s0 ^ (s0 >> 17);
          s0 = s0 ^ (s0 << 5);
          wa = {32'd0, s0};
          return s0;
        end
        FAM_XS64S: begin
          x = wa;
          x = x ^ (x >> 12);
          x = x ^ (x << 25);
          x = x ^ (x >> 27);
          wa = x;
          x = x * XS64S_MUL;
          return x[63:32];
        end
        FAM_SPLITMIX: begin
          wa = wa + SM_GAMMA;
          x = wa;
          x = (x ^ (x >> 30)) * SM_MUL1;
          x = (x ^ (x >> 27)) * SM_MUL2;
          x = x ^ (x >> 31);
          return x[63:32];
        end
        FAM_PCG32: begin
          x = wa;
          wa = x * LCG64_MUL + (wb | 64'd1);
          t = ((x >> 18) ^ x) >> 27;
          xs32 = t[31:0];
          rot = {1'b0, x[63:59]};
          return (xs32 >> rot) | (xs32 << ((32 - rot) & 31));
        end
        FAM_LCG64: begin
          wa = wa * LCG64_MUL + LCG64_ADD;
          return wa[63:32];
        end
        FAM_XOSHIRO256: begin
          r = rotl64(wb * 64'd5, 7) * 64'd9;
          t = wb << 17;
          wc = wc ^ wa;
          wd = wd ^ wb;
          wb = wb ^ wc;
          wa = wa ^ wd;
          wc = wc ^ t;
          wd = rotl64(wd, 45);
          return r[63:32];
        end
        FAM_XOSHIRO128: begin
          s0 = wa[31:0]; s1 = wb[31:0]; s2 = wc[31:0]; s3 = wd[31:0];
          r32 = rotl32(s1 * 32'd5, 7) * 32'd9;
          t32 = s1 << 9;
          s2 = s2 ^ s0;
          s3 = s3 ^ s1;
          s1 = s1 ^ s2;
          s0 = s0 ^ s3;
          s2 = s2 ^ t32;
          s3 = rotl32(s3, 11);
          wa = {32'd0, s0}; wb = {32'd0, s1}; wc = {32'd0, s2}; wd = {32'd0, s3};
          return r32;
        end
        FAM_XOROSHIRO: begin
          r = wa + wb;
          x = wb ^ wa;
          wa = rotl64(wa, 24) ^ x ^ (x << 16);
          wb = rotl64(x, 37);
          return r[63:32];
        end
        default: begin
          prod = {64'd0, wa} * {64'd0, P64_ML};
          nlo = prod[63:0] + 64'd1;
          nhi = prod[127:64] + wa * P64_MH + wb * P64_ML;
          if (nlo == 0) nhi = nhi + 64'd1;
          nhi = nhi + P64_INC_HI;
          wa = nlo;
          wb = nhi;
          xs = nhi ^ nlo;
          rot = nhi[63:58];
          x = (xs >> rot) | (xs << ((64 - rot) & 63));
          return x[63:32];
        end
      endcase
    endfunction

    // Note an accepted input transfer
    function void note_transfer(logic cmd, logic [63:0] seed);
      if (cmd == CMD_LOAD) load_seed(seed);
      else pending_words.push_back(draw_word());
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Check a result transfer against the oldest expected word
    task check_value(logic [31:0] value);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result %h", value));
      end else begin
        want = pending_words.pop_front();
        draws_checked++;
        if (value !== want)
          report($sformatf("value %h, expected %h (family %0d)", value, want, family));
      end
    endtask
  endclass

  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_LOAD;
  logic [63:0] in_seed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;

  prng_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  long_hold = 0;
  int  cycle_count = 0;
  int  items_sent = 0;

  multi_family_prng uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_seed(in_seed),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check result transfers and drive the stall, with an optional long hold
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_value(out_value);
    if (long_hold > 0) begin
      long_hold = long_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one item and hold it until the transfer
  task send_item(logic cmd, logic [63:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_seed <= seed;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(cmd, seed);
    items_sent++;
  endtask

  // Drain outstanding results, let the block settle, then write the family
  task write_family(logic [3:0] fam);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fam;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.family = fam;
  endtask

  function logic [63:0] pick_seed();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {$urandom, 32'd0};
      3: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: draw from the reset state, extreme seeds
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, '0);
    send_item(CMD_LOAD, '0);
    send_item(CMD_DRAW, '1);
    send_item(CMD_LOAD, '1);
    send_item(CMD_DRAW, '0);
    send_item(CMD_LOAD, 64'hFFFF_FFFF_0000_0000);
    send_item(CMD_DRAW, '0);

    // Random: every family code, each with one of four idling patterns
    for (int fam = 0; fam < 16; fam++) begin
      write_family(fam[3:0]);
      case (fam % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (fam == 7) long_hold = 600;
      // Sometimes draw on the state left by the previous family
      if (fam % 3 == 1) send_item(CMD_DRAW, pick_seed());
      n = 0;
      while (n < 105) begin
        if ($urandom_range(9) == 0) begin
          send_item(1'($urandom_range(1)), pick_seed());
          n++;
        end else begin
          send_item(CMD_LOAD, pick_seed());
          repeat ($urandom_range(8, 1)) send_item(CMD_DRAW, pick_seed());
          n += 5;
        end
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items over family codes 0 to 15; checked %0d drawn words.",
             items_sent, sb.draws_checked);
    $display("Covered seed loads, draws from stale state and long output stalls.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/mfp_pkg.sv
design/mfp_mul.sv
design/multi_family_prng.sv
verif/multi_family_prng_tb.sv
